// ----- hdl/rbka_pkg.sv -----
// ----------------------------------------------------------------------------
// rbka_pkg
// Shared constants, state type and controller/datapath bundles for the
// engine-speed binned knock average.
// ----------------------------------------------------------------------------
package rbka_pkg;

    // default sizing
    localparam int SPEED_BINS_DEF      = 128;
    localparam int SAMPLES_PER_BIN_DEF = 16;

    // speed to bin mapping: bin = floor((rpm - 200 + 30) / 60)
    localparam int SPEED_OFFSET = 200;
    localparam int SPEED_STEP   = 60;
    localparam int HALF_STEP    = SPEED_STEP / 2;

    // divide by the step as floor(x / 60) = ((x >> 2) * 8739) >> 17,
    // exact for any 15-bit x
    localparam int MAP_PRE_SHIFT = 2;
    localparam int MAP_RECIP     = 8739;
    localparam int MAP_RECIP_W   = 14;
    localparam int MAP_SHIFT     = 17;

    // item field widths
    localparam int SPEED_W     = 15;
    localparam int LEVEL_W     = 16;
    localparam int INDEX_W     = 7;
    localparam int COUNT_OUT_W = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // opcodes carried in tuser
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_GO,
        ST_BIN_RD,
        ST_BIN_WT,
        ST_SLOT,
        ST_REPLACE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_RESULT
    } rbka_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic div_start;
        logic latch_bin;
        logic bin_rd;
        logic latch_state;
        logic ring_rd;
        logic store_fill;
        logic store_replace;
        logic out_load;
    } rbka_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic item_read;
        logic div_done;
        logic bin_full;
        logic bin_empty;
        logic out_free;
    } rbka_status_t;

endpackage

// ----- hdl/rpm_binned_knock_average.sv -----
// ----------------------------------------------------------------------------
// rpm_binned_knock_average
// Engine-speed binned moving average of knock-sensor level.
// ----------------------------------------------------------------------------
// A store item (tuser = 0) puts its knock level into the speed bin
// round((rpm - 200) / 60), clamped to 0..SPEED_BINS-1, keeping the last
// SAMPLES_PER_BIN samples of each bin and a running sum; it gives no result.
// A read item (tuser = 1) gives the rounded mean and the sample count of one
// bin, or zeros for an empty or out-of-range bin. Items are handled one at a
// time; a finished result waits in the output register while the next item
// is taken. The speed-to-bin map is a reciprocal multiplication; the mean
// comes from a restoring divider of SUM_W = 16 + clog2(SAMPLES_PER_BIN + 1)
// bits (21 by default) that yields one quotient bit per cycle. A store into
// a full bin reads its oldest sample back and replaces it, and a read of an
// empty or out-of-range bin skips the divider; a read result is offered in
// the cycle the block is ready again, and a read takes longer while the
// previous result has not been taken. After reset a clearing pass zeroes the
// per-bin state before the first item is taken.
// ----------------------------------------------------------------------------
module rpm_binned_knock_average #(
    parameter int SPEED_BINS      = rbka_pkg::SPEED_BINS_DEF,
    parameter int SAMPLES_PER_BIN = rbka_pkg::SAMPLES_PER_BIN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // engine_speed[14:0], knock_level[30:15], bin_index[37:31], zero pad
    input  logic [rbka_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // opcode[0]
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // average_level[15:0], samples_in_bin[20:16], zero pad
    output logic [rbka_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready
);

    rbka_pkg::rbka_cmd_t               cmd;
    rbka_pkg::rbka_status_t            status;
    logic [rbka_pkg::LEVEL_W-1:0]      average_level;
    logic [rbka_pkg::COUNT_OUT_W-1:0]  samples_in_bin;

    rbka_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rbka_datapath #(
        .SPEED_BINS      (SPEED_BINS),
        .SAMPLES_PER_BIN (SAMPLES_PER_BIN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_kind     (s_axis_tuser),
        .in_speed    (s_axis_tdata[14:0]),
        .in_level    (s_axis_tdata[30:15]),
        .in_index    (s_axis_tdata[37:31]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_average (average_level),
        .out_count   (samples_in_bin)
    );

    // pack the result item
    assign m_axis_tdata = {3'b000, samples_in_bin, average_level};

endmodule

// ----- hdl/rbka_ram.sv -----
// ----------------------------------------------------------------------------
// rbka_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module rbka_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/rbka_div.sv -----
// ----------------------------------------------------------------------------
// rbka_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module rbka_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
    end

    // iteration control
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            den_next = den;
            cnt_next = CW'(NUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- hdl/rbka_datapath.sv -----
// ----------------------------------------------------------------------------
// rbka_datapath
// Item registers, per-bin state memory, sample ring memory, speed-to-bin
// map, mean divider and output register of the binned knock average.
// ----------------------------------------------------------------------------
module rbka_datapath #(
    parameter int SPEED_BINS      = rbka_pkg::SPEED_BINS_DEF,
    parameter int SAMPLES_PER_BIN = rbka_pkg::SAMPLES_PER_BIN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rbka_pkg::rbka_cmd_t                 cmd,
    output rbka_pkg::rbka_status_t              status,
    input  logic                                in_kind,
    input  logic [rbka_pkg::SPEED_W-1:0]        in_speed,
    input  logic [rbka_pkg::LEVEL_W-1:0]        in_level,
    input  logic [rbka_pkg::INDEX_W-1:0]        in_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rbka_pkg::LEVEL_W-1:0]        out_average,
    output logic [rbka_pkg::COUNT_OUT_W-1:0]    out_count
);

    localparam int BIN_W      = $clog2(SPEED_BINS);
    localparam int PTR_W      = (SAMPLES_PER_BIN > 1) ? $clog2(SAMPLES_PER_BIN) : 1;
    localparam int CNT_W      = $clog2(SAMPLES_PER_BIN + 1);
    localparam int SUM_W      = rbka_pkg::LEVEL_W + CNT_W;
    localparam int RING_D     = SPEED_BINS * SAMPLES_PER_BIN;
    localparam int RING_AW    = $clog2(RING_D);
    localparam int BW         = PTR_W + CNT_W + SUM_W;
    localparam int MAP_IN_W   = rbka_pkg::SPEED_W - rbka_pkg::MAP_PRE_SHIFT;
    localparam int MAP_PROD_W = MAP_IN_W + rbka_pkg::MAP_RECIP_W;
    localparam int MAP_QUO_W  = MAP_PROD_W - rbka_pkg::MAP_SHIFT;

    // item registers
    logic                              kind_reg;
    logic [rbka_pkg::SPEED_W-1:0]      speed_reg;
    logic [rbka_pkg::LEVEL_W-1:0]      level_reg;
    logic [BIN_W-1:0]                  bin_reg, bin_next;
    logic                              in_range_reg;

    // bin state registers
    logic [PTR_W-1:0]                  ptr_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [SUM_W-1:0]                  sum_reg;

    // control registers
    logic [BIN_W-1:0]                  clr_cnt_reg, clr_cnt_next;
    logic                              out_valid_reg, out_valid_next;
    logic [rbka_pkg::LEVEL_W-1:0]      out_avg_reg;
    logic [rbka_pkg::COUNT_OUT_W-1:0]  out_cnt_reg;

    // memories and divider
    logic                              bin_wr_en;
    logic [BIN_W-1:0]                  bin_wr_addr;
    logic [BW-1:0]                     bin_wr_data;
    logic [BW-1:0]                     bin_rd_data;
    logic                              ring_wr_en;
    logic [RING_AW-1:0]                ring_addr;
    logic [rbka_pkg::LEVEL_W-1:0]      ring_rd_data;
    logic [SUM_W-1:0]                  div_num;
    logic [CNT_W-1:0]                  div_den;
    logic                              div_done;
    logic [SUM_W-1:0]                  div_quo;

    // speed to bin map
    logic [rbka_pkg::SPEED_W-1:0]      map_offset;
    logic [MAP_PROD_W-1:0]             map_prod;
    logic [MAP_QUO_W-1:0]              map_quo;

    // ring slot and updated bin fields
    logic                              bin_full;
    logic [PTR_W-1:0]                  ptr_eff;
    logic [PTR_W-1:0]                  ptr_adv;
    logic [PTR_W-1:0]                  slot;
    logic [SUM_W-1:0]                  sum_fill;
    logic [SUM_W-1:0]                  sum_replace;

    always_comb
    begin
        bin_full    = (cnt_reg >= CNT_W'(SAMPLES_PER_BIN));
        ptr_eff     = (ptr_reg > PTR_W'(SAMPLES_PER_BIN - 1)) ? '0 : ptr_reg;
        ptr_adv     = (ptr_eff == PTR_W'(SAMPLES_PER_BIN - 1)) ? '0 : ptr_eff + PTR_W'(1);
        slot        = bin_full ? ptr_eff : PTR_W'(cnt_reg);
        sum_fill    = sum_reg + SUM_W'(level_reg);
        sum_replace = sum_reg - SUM_W'(ring_rd_data) + SUM_W'(level_reg);
        ring_addr   = RING_AW'(bin_reg * SAMPLES_PER_BIN) + RING_AW'(slot);
    end

    // divider operands: rounded mean of the bin
    always_comb
    begin
        div_num = sum_reg + SUM_W'(cnt_reg >> 1);
        div_den = cnt_reg;
    end

    // speed to bin: add half a step past the offset, divide by the step
    always_comb
    begin
        if (speed_reg < rbka_pkg::SPEED_W'(rbka_pkg::SPEED_OFFSET))
        begin
            map_offset = '0;
        end
        else
        begin
            map_offset = speed_reg - rbka_pkg::SPEED_W'(
                rbka_pkg::SPEED_OFFSET - rbka_pkg::HALF_STEP);
        end
        map_prod = MAP_PROD_W'(map_offset[rbka_pkg::SPEED_W-1:rbka_pkg::MAP_PRE_SHIFT])
                 * MAP_PROD_W'(rbka_pkg::MAP_RECIP);
        map_quo  = map_prod[MAP_PROD_W-1:rbka_pkg::MAP_SHIFT];
    end

    // bin register: read index on accept, clamped map result for a store
    always_comb
    begin
        bin_next = bin_reg;
        if (cmd.load_item)
        begin
            bin_next = BIN_W'(in_index);
        end
        else if (cmd.latch_bin)
        begin
            if (map_quo > MAP_QUO_W'(SPEED_BINS - 1))
            begin
                bin_next = BIN_W'(SPEED_BINS - 1);
            end
            else
            begin
                bin_next = BIN_W'(map_quo);
            end
        end
    end

    // bin state write port: clearing pass or store update
    always_comb
    begin
        bin_wr_en   = cmd.clear_wr | cmd.store_fill | cmd.store_replace;
        bin_wr_addr = cmd.clear_wr ? clr_cnt_reg : bin_reg;
        if (cmd.clear_wr)
        begin
            bin_wr_data = '0;
        end
        else if (cmd.store_fill)
        begin
            bin_wr_data = {ptr_reg, cnt_reg + CNT_W'(1), sum_fill};
        end
        else
        begin
            bin_wr_data = {ptr_adv, cnt_reg, sum_replace};
        end
        ring_wr_en = cmd.store_fill | cmd.store_replace;
    end

    // clear counter and output valid
    always_comb
    begin
        clr_cnt_next = cmd.clear_wr ? clr_cnt_reg + BIN_W'(1) : clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        if (cmd.load_item)
        begin
            kind_reg     <= in_kind;
            speed_reg    <= in_speed;
            level_reg    <= in_level;
            in_range_reg <= (int'(in_index) < SPEED_BINS);
        end
        if (cmd.latch_state)
        begin
            ptr_reg <= bin_rd_data[BW-1 -: PTR_W];
            cnt_reg <= bin_rd_data[SUM_W +: CNT_W];
            sum_reg <= bin_rd_data[SUM_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_avg_reg <= status.bin_empty ? '0 : rbka_pkg::LEVEL_W'(div_quo);
            out_cnt_reg <= in_range_reg ? rbka_pkg::COUNT_OUT_W'(cnt_reg) : '0;
        end
    end

    rbka_ram #(
        .WIDTH (BW),
        .DEPTH (SPEED_BINS)
    ) u_bin_ram (
        .clk     (clk),
        .wr_en   (bin_wr_en),
        .wr_addr (bin_wr_addr),
        .wr_data (bin_wr_data),
        .rd_en   (cmd.bin_rd),
        .rd_addr (bin_reg),
        .rd_data (bin_rd_data)
    );

    rbka_ram #(
        .WIDTH (rbka_pkg::LEVEL_W),
        .DEPTH (RING_D)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_addr),
        .wr_data (level_reg),
        .rd_en   (cmd.ring_rd),
        .rd_addr (ring_addr),
        .rd_data (ring_rd_data)
    );

    rbka_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // status back to the controller
    always_comb
    begin
        status.clear_last = (clr_cnt_reg == BIN_W'(SPEED_BINS - 1));
        status.item_read  = (kind_reg == rbka_pkg::OP_READ);
        status.div_done   = div_done;
        status.bin_full   = bin_full;
        status.bin_empty  = !in_range_reg || (cnt_reg == '0);
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_average = out_avg_reg;
    assign out_count   = out_cnt_reg;

endmodule

// ----- hdl/rbka_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbka_ctrl
// Sequencer for the binned knock average: clearing pass, store and read
// flows, driving the datapath through command and status bundles.
// ----------------------------------------------------------------------------
module rbka_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_kind,
    output logic                   in_ready,
    input  rbka_pkg::rbka_status_t status,
    output rbka_pkg::rbka_cmd_t    cmd
);

    rbka_pkg::rbka_state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbka_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = rbka_pkg::ST_IDLE;
                end
            end
            rbka_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_kind == rbka_pkg::OP_READ) ? rbka_pkg::ST_BIN_RD
                                                                : rbka_pkg::ST_MAP_GO;
                end
            end
            rbka_pkg::ST_MAP_GO:
            begin
                state_next = rbka_pkg::ST_BIN_RD;
            end
            rbka_pkg::ST_BIN_RD:
            begin
                state_next = rbka_pkg::ST_BIN_WT;
            end
            rbka_pkg::ST_BIN_WT:
            begin
                state_next = status.item_read ? rbka_pkg::ST_AVG_GO : rbka_pkg::ST_SLOT;
            end
            rbka_pkg::ST_SLOT:
            begin
                state_next = status.bin_full ? rbka_pkg::ST_REPLACE : rbka_pkg::ST_IDLE;
            end
            rbka_pkg::ST_REPLACE:
            begin
                state_next = rbka_pkg::ST_IDLE;
            end
            rbka_pkg::ST_AVG_GO:
            begin
                state_next = status.bin_empty ? rbka_pkg::ST_RESULT : rbka_pkg::ST_AVG_WAIT;
            end
            rbka_pkg::ST_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = rbka_pkg::ST_RESULT;
                end
            end
            rbka_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = rbka_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbka_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            rbka_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            rbka_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            rbka_pkg::ST_MAP_GO:
            begin
                cmd.latch_bin = 1'b1;
            end
            rbka_pkg::ST_BIN_RD:
            begin
                cmd.bin_rd = 1'b1;
            end
            rbka_pkg::ST_BIN_WT:
            begin
                cmd.latch_state = 1'b1;
            end
            rbka_pkg::ST_SLOT:
            begin
                cmd.ring_rd    = status.bin_full;
                cmd.store_fill = !status.bin_full;
            end
            rbka_pkg::ST_REPLACE:
            begin
                cmd.store_replace = 1'b1;
            end
            rbka_pkg::ST_AVG_GO:
            begin
                cmd.div_start = !status.bin_empty;
            end
            rbka_pkg::ST_AVG_WAIT:
            begin
                cmd = '0;
            end
            rbka_pkg::ST_RESULT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbka_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
